// ===== rtl/core/plc_pkg.sv =====
// Shared types, format codes and colour conversion helpers for the palette block.
`timescale 1ns / 1ps

package plc_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int QUEUE_DEPTH         = 4;
  localparam int PIXEL_W             = 32;
  localparam int TRUNC_W             = 24;
  localparam int ROUND_W             = 16;
  localparam int FMT_W               = 3;
  localparam int CFG_ADDR_W          = 3;
  localparam int CFG_DATA_W          = 32;

  // register index as seen in paddr[2]
  localparam logic REG_PIXEL_FORMAT = 1'b0;

  typedef enum logic [FMT_W-1:0] {
    FMT_PASS      = 3'd0,
    FMT_RGB555    = 3'd1,
    FMT_BGR555    = 3'd2,
    FMT_RGB565    = 3'd3,
    FMT_BGR565    = 3'd4,
    FMT_WORD_RLOW = 3'd5,
    FMT_WORD_BLOW = 3'd6
  } fmt_t;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_PASS  = 2'd2,
    ACT_ZERO  = 2'd3
  } act_t;

  typedef struct packed {
    logic       op;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       dither_bit;
    logic       last_entry;
  } item_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [PIXEL_W-1:0] pixel_value;
    logic               batch_done;
  } result_t;

  // one classified item, as queued between front and back
  typedef struct packed {
    act_t               act;
    logic [7:0]         index;
    logic               wr_trunc;
    logic               wr_round;
    logic               dither_sel;
    logic               last;
    logic [TRUNC_W-1:0] trunc;
    logic [ROUND_W-1:0] rnd;
  } job_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  function automatic logic [7:0] round5(input logic [7:0] c);
    logic [8:0] sum;
    logic [8:0] e;
    sum = {1'b0, c} + 9'd4;
    e   = {sum[8:3], 3'b000};
    return (e > 9'h0F8) ? 8'hF8 : e[7:0];
  endfunction

  function automatic logic [7:0] round6(input logic [7:0] c);
    logic [8:0] sum;
    logic [8:0] e;
    sum = {1'b0, c} + 9'd2;
    e   = {sum[8:2], 2'b00};
    return (e > 9'h0FC) ? 8'hFC : e[7:0];
  endfunction

  // components are full 8-bit values; only their top bits land in the word
  function automatic logic [15:0] pack555(input logic [7:0] hi, input logic [7:0] g,
                                          input logic [7:0] lo);
    return {1'b0, hi[7:3], g[7:3], lo[7:3]};
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] hi, input logic [7:0] g,
                                          input logic [7:0] lo);
    return {hi[7:3], g[7:2], lo[7:3]};
  endfunction

endpackage

// ===== rtl/core/palette_convert_and_lookup.sv =====
// Top level of the palette lookup block with pixel-format conversion.
// Palette writes and pixel lookups stream through at one item per clock while not stalled:
// the front end classifies and converts each item in its accept cycle and queues it, and
// the back end makes one palette store access per cycle (a write of one or both colour
// copies, or a read of both at one index) and registers the result. Sustained rate is set
// by that single access per cycle to the store. The store is not cleared at reset; no pixel
// may look up an entry before it is written. The user must write the format register only
// while no item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module palette_convert_and_lookup import plc_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  fmt_t      pixel_format;
  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head;
  q_status_t q_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PIXEL_FORMAT) ? CFG_DATA_W'(pixel_format) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_PASS;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIXEL_FORMAT) begin
      pixel_format <= fmt_t'(pwdata[FMT_W-1:0]);
    end
  end

  plc_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .pixel_format (pixel_format),
    .q_status     (q_status),
    .push         (push),
    .job          (push_job)
  );

  plc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  plc_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/core/plc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module plc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/plc_front.sv =====
// Front end: accepts items, classifies them and converts palette colours.
`timescale 1ns / 1ps

module plc_front import plc_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic      item_valid,
  output logic      item_stall,
  input  item_t     item,
  input  fmt_t      pixel_format,
  input  q_status_t q_status,
  output logic      push,
  output job_t      job
);

  logic in_range;
  logic dual;
  logic word;

  assign item_stall = q_status.full;
  assign push       = item_valid && !q_status.full;
  assign in_range   = {1'b0, item.entry_index} < 9'(PALETTE_ENTRIES);

  always_comb begin
    job        = '0;
    job.index  = item.entry_index;
    job.last   = item.last_entry;
    dual       = 1'b0;
    word       = 1'b0;
    case (pixel_format)
      FMT_RGB555: begin
        dual      = 1'b1;
        job.trunc = TRUNC_W'(pack555(item.red, item.green, item.blue));
        job.rnd   = pack555(round5(item.red), round5(item.green), round5(item.blue));
      end
      FMT_BGR555: begin
        dual      = 1'b1;
        job.trunc = TRUNC_W'(pack555(item.blue, item.green, item.red));
        job.rnd   = pack555(round5(item.blue), round5(item.green), round5(item.red));
      end
      FMT_RGB565: begin
        dual      = 1'b1;
        job.trunc = TRUNC_W'(pack565(item.red, item.green, item.blue));
        job.rnd   = pack565(round5(item.red), round6(item.green), round5(item.blue));
      end
      FMT_BGR565: begin
        dual      = 1'b1;
        job.trunc = TRUNC_W'(pack565(item.blue, item.green, item.red));
        job.rnd   = pack565(round5(item.blue), round6(item.green), round5(item.red));
      end
      FMT_WORD_RLOW: begin
        word      = 1'b1;
        job.trunc = {item.blue, item.green, item.red};
      end
      FMT_WORD_BLOW: begin
        word      = 1'b1;
        job.trunc = {item.red, item.green, item.blue};
      end
      default: begin
        dual = 1'b0;
        word = 1'b0;
      end
    endcase

    if (item.op == OP_WRITE) begin
      job.act      = ACT_WRITE;
      job.wr_trunc = in_range && (dual || word);
      job.wr_round = in_range && dual;
    end else if (!(dual || word)) begin
      job.act = ACT_PASS;
    end else if (!in_range) begin
      job.act = ACT_ZERO;
    end else begin
      job.act        = ACT_READ;
      job.dither_sel = dual && item.dither_bit;
    end
  end

endmodule

// ===== rtl/core/plc_queue.sv =====
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps

module plc_queue import plc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head            = slots[rd_ptr];
  assign status.full     = (count == CNT_W'(DEPTH));
  assign status.nonempty = (count != '0);

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/plc_back.sv =====
// Back end: palette store access, result formation and output register.
`timescale 1ns / 1ps

module plc_back import plc_pkg::*; #(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t q_status,
  input  job_t      head,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_stall,
  output result_t   result
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  logic               a_valid;
  act_t               a_act;
  logic [7:0]         a_index;
  logic               a_dither;
  logic               a_last;
  logic               a_adv;
  logic [TRUNC_W-1:0] trunc_rdata;
  logic [ROUND_W-1:0] round_rdata;
  logic [IDX_W-1:0]   addr;
  result_t            a_result;

  assign a_adv = a_valid && (!result_valid || !result_stall);
  assign pop   = q_status.nonempty && (!a_valid || a_adv);
  assign addr  = head.index[IDX_W-1:0];

  // truncated or full colour copy
  plc_ram #(.WIDTH(TRUNC_W), .DEPTH(PALETTE_ENTRIES)) u_trunc_ram (
    .clk   (clk),
    .we    (pop && head.act == ACT_WRITE && head.wr_trunc),
    .waddr (addr),
    .wdata (head.trunc),
    .re    (pop && head.act == ACT_READ),
    .raddr (addr),
    .rdata (trunc_rdata)
  );

  // rounded, saturated colour copy
  plc_ram #(.WIDTH(ROUND_W), .DEPTH(PALETTE_ENTRIES)) u_round_ram (
    .clk   (clk),
    .we    (pop && head.act == ACT_WRITE && head.wr_round),
    .waddr (addr),
    .wdata (head.rnd),
    .re    (pop && head.act == ACT_READ),
    .raddr (addr),
    .rdata (round_rdata)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      a_act    <= head.act;
      a_index  <= head.index;
      a_dither <= head.dither_sel;
      a_last   <= head.last;
    end
  end

  always_comb begin
    a_result = '0;
    case (a_act)
      ACT_WRITE: a_result.batch_done = a_last;
      ACT_READ: begin
        a_result.pixel_valid = 1'b1;
        a_result.pixel_value = a_dither ? PIXEL_W'(round_rdata) : PIXEL_W'(trunc_rdata);
      end
      ACT_PASS: begin
        a_result.pixel_valid = 1'b1;
        a_result.pixel_value = PIXEL_W'(a_index);
      end
      ACT_ZERO: a_result.pixel_valid = 1'b1;
      default:  a_result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      result <= a_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (!result_valid || !result_stall) begin
        result_valid <= a_valid;
      end
    end
  end

endmodule

// ===== rtl/core/plc_checker.sv =====
// Port-level checks for the palette block, bound to the top level.
`timescale 1ns / 1ps

module plc_checker import plc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not empty after reset");

  // write acknowledgements carry no pixel
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.pixel_valid |-> result.pixel_value == '0)
    else $error("write result carries a pixel value");

  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.pixel_valid && result.batch_done))
    else $error("lookup result flags batch done");

endmodule

bind palette_convert_and_lookup plc_checker u_plc_checker (.*);
